>>> sv/fdem_pkg.sv
// ============================================================================
// fdem_pkg
// Shared types, codes and helpers for the FAT directory entry matcher.
// ============================================================================
`default_nettype none

package fdem_pkg;

    localparam int unsigned ENTRY_LEN = 32;
    localparam int unsigned NAME_LEN  = 11;
    localparam int unsigned POS_W     = $clog2(ENTRY_LEN);

    localparam logic [7:0] MARK_END     = 8'h00;
    localparam logic [7:0] MARK_DELETED = 8'hE5;
    localparam logic [7:0] ATTR_VOLID   = 8'h08;

    localparam logic [POS_W-1:0] POS_ATTR    = POS_W'(NAME_LEN);
    localparam logic [POS_W-1:0] POS_CLU_HI0 = POS_W'(20);
    localparam logic [POS_W-1:0] POS_CLU_HI1 = POS_W'(21);
    localparam logic [POS_W-1:0] POS_CLU_LO0 = POS_W'(26);
    localparam logic [POS_W-1:0] POS_CLU_LO1 = POS_W'(27);
    localparam logic [POS_W-1:0] POS_SIZE0   = POS_W'(28);
    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(ENTRY_LEN - 1);

    // configuration register indexes
    localparam logic CFG_TARGET_NAME = 1'b0;
    localparam logic CFG_TARGET_EXT  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_FOUND    = 2'd0,
        STATUS_END_MARK = 2'd1,
        STATUS_NO_MATCH = 2'd2
    } status_t;

    // one result item
    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [31:0] start_cluster;
        logic [31:0] file_length;
    } result_t;

    // scanner state seen from outside (checks only)
    typedef struct packed {
        logic             search_over;
        logic [POS_W-1:0] byte_position;
    } scan_status_t;

    // target name byte k of the 8.3 name, k below NAME_LEN
    function automatic logic [7:0] name_byte(input logic [63:0] name,
                                             input logic [23:0] ext,
                                             input logic [3:0]  k);
        logic [7:0] b;
        b = 8'h00;
        case (k)
            4'd0:    b = name[7:0];
            4'd1:    b = name[15:8];
            4'd2:    b = name[23:16];
            4'd3:    b = name[31:24];
            4'd4:    b = name[39:32];
            4'd5:    b = name[47:40];
            4'd6:    b = name[55:48];
            4'd7:    b = name[63:56];
            4'd8:    b = ext[7:0];
            4'd9:    b = ext[15:8];
            4'd10:   b = ext[23:16];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> sv/fdem_scan.sv
// ============================================================================
// fdem_scan
// Entry scanner: holds the per-entry state and forms the result of one byte.
// ============================================================================
`default_nettype none

module fdem_scan
    import fdem_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         step,        // byte in the input register is consumed
    input  wire logic [7:0]   dir_byte,
    input  wire logic         stream_end,
    input  wire logic [63:0]  target_name,
    input  wire logic [23:0]  target_ext,
    output result_t           result,
    output scan_status_t      scan_status
);

    logic [POS_W-1:0] byte_position_reg, byte_position_next;
    logic             name_mismatch_reg, name_mismatch_next;
    logic             entry_skipped_reg, entry_skipped_next;
    logic [15:0]      cluster_high_reg, cluster_high_next;
    logic [15:0]      cluster_low_reg, cluster_low_next;
    logic [31:0]      size_bytes_reg, size_bytes_next;
    logic             search_over_reg, search_over_next;

    logic pos_zero;
    logic in_name;

    assign pos_zero = (byte_position_reg == '0);
    assign in_name  = (byte_position_reg < POS_W'(NAME_LEN));

    always_comb begin
        byte_position_next = byte_position_reg;
        name_mismatch_next = name_mismatch_reg;
        entry_skipped_next = entry_skipped_reg;
        cluster_high_next  = cluster_high_reg;
        cluster_low_next   = cluster_low_reg;
        size_bytes_next    = size_bytes_reg;
        search_over_next   = search_over_reg;
        result             = '0;

        if (step && !search_over_reg) begin
            if (pos_zero) begin
                name_mismatch_next = 1'b0;
                entry_skipped_next = 1'b0;
            end
            if (pos_zero && dir_byte == MARK_END) begin
                result.valid     = 1'b1;
                result.status    = STATUS_END_MARK;
                search_over_next = 1'b1;
            end else begin
                if (pos_zero && dir_byte == MARK_DELETED) begin
                    entry_skipped_next = 1'b1;
                end
                if (in_name && dir_byte != name_byte(target_name, target_ext,
                                                     byte_position_reg[3:0])) begin
                    name_mismatch_next = 1'b1;
                end
                if (byte_position_reg == POS_ATTR && (dir_byte & ATTR_VOLID) != 8'h00) begin
                    entry_skipped_next = 1'b1;
                end
                if (byte_position_reg == POS_CLU_HI0 || byte_position_reg == POS_CLU_HI1) begin
                    cluster_high_next = {dir_byte, cluster_high_reg[15:8]};
                end
                if (byte_position_reg == POS_CLU_LO0 || byte_position_reg == POS_CLU_LO1) begin
                    cluster_low_next = {dir_byte, cluster_low_reg[15:8]};
                end
                if (byte_position_reg >= POS_SIZE0) begin
                    size_bytes_next = {dir_byte, size_bytes_reg[31:8]};
                end
                if (byte_position_reg == POS_LAST && !entry_skipped_next
                        && !name_mismatch_next) begin
                    result.valid         = 1'b1;
                    result.status        = STATUS_FOUND;
                    result.start_cluster = {cluster_high_next, cluster_low_next};
                    result.file_length   = size_bytes_next;
                    search_over_next     = 1'b1;
                end
                // wraps to zero after the last byte of an entry
                byte_position_next = byte_position_reg + POS_W'(1);
            end
        end

        if (step && stream_end) begin
            if (!result.valid && !search_over_reg) begin
                result.valid  = 1'b1;
                result.status = STATUS_NO_MATCH;
            end
            byte_position_next = '0;
            name_mismatch_next = 1'b0;
            entry_skipped_next = 1'b0;
            cluster_high_next  = '0;
            cluster_low_next   = '0;
            size_bytes_next    = '0;
            search_over_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg <= '0;
            name_mismatch_reg <= 1'b0;
            entry_skipped_reg <= 1'b0;
            cluster_high_reg  <= '0;
            cluster_low_reg   <= '0;
            size_bytes_reg    <= '0;
            search_over_reg   <= 1'b0;
        end else begin
            byte_position_reg <= byte_position_next;
            name_mismatch_reg <= name_mismatch_next;
            entry_skipped_reg <= entry_skipped_next;
            cluster_high_reg  <= cluster_high_next;
            cluster_low_reg   <= cluster_low_next;
            size_bytes_reg    <= size_bytes_next;
            search_over_reg   <= search_over_next;
        end
    end

    assign scan_status.search_over   = search_over_reg;
    assign scan_status.byte_position = byte_position_reg;

endmodule

`default_nettype wire

>>> sv/fat_directory_entry_matcher.sv
// ============================================================================
// fat_directory_entry_matcher
// Looks up an 8.3 name in a stream of FAT directory bytes.
// ============================================================================
// The block takes one directory byte per item and one item per clock cycle
// unless m_tready stalls the result register. Each byte passes an input
// register, the entry scanner and a result register; the result register
// loads as the byte in the input register steps through the scanner.
// The byte that completes a matching 32-byte
// entry gives "found" with the cluster and size, a zero first byte of an
// entry gives "end of directory", and s_tlast with no earlier result gives
// "not found". After a result, bytes are dropped until s_tlast, which rearms
// the scan. The two pipeline registers advance together whenever the result
// register is empty or being read, so a stall on m_tready holds the input side
// in the same cycle. Write target_name and target_ext only while no item is
// in flight.
// ============================================================================
`default_nettype none

module fat_directory_entry_matcher
    import fdem_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,     // 0 target_name, 1 target_ext
    input  wire logic [63:0] cfg_wdata,

    // directory bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] dir_byte
    input  wire logic        s_tlast,       // stream_end

    // lookup result
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,       // [31:0] start cluster, [63:32] file length
    output logic [1:0]       m_tuser        // [1:0] status
);

    // ---- configuration ------------------------------------------------------
    logic [63:0] target_name_reg;
    logic [23:0] target_ext_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_name_reg <= 64'h2020_2020_2020_2020;   // eight spaces
            target_ext_reg  <= 24'h20_2020;               // three spaces
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TARGET_NAME: target_name_reg <= cfg_wdata;
                CFG_TARGET_EXT:  target_ext_reg  <= cfg_wdata[23:0];
                default:         target_name_reg <= target_name_reg;
            endcase
        end
    end

    // ---- pipeline control ---------------------------------------------------
    logic advance;      // both stages move this cycle
    logic step;         // byte in the input register goes through the scanner

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    result_t    out_reg, out_next;
    logic       out_valid_reg, out_valid_next;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    // ---- input register -----------------------------------------------------
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // ---- entry scanner ------------------------------------------------------
    result_t      scan_result;
    scan_status_t scan_status;

    fdem_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .dir_byte    (in_byte_reg),
        .stream_end  (in_last_reg),
        .target_name (target_name_reg),
        .target_ext  (target_ext_reg),
        .result      (scan_result),
        .scan_status (scan_status)
    );

    // ---- result register ----------------------------------------------------
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance) begin
            out_valid_next = step && scan_result.valid;
            out_next       = scan_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.file_length, out_reg.start_cluster};
    assign m_tuser  = out_reg.status;

`ifndef SYNTHESIS
    // stream end rearms the scan
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && in_last_reg |=> !scan_status.search_over && scan_status.byte_position == '0)
        else $error("scan not rearmed after stream end");

    // once a result is given, only stream end can produce another one
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && scan_status.search_over && !in_last_reg |-> !scan_result.valid)
        else $error("result given while search is over");

    // end-of-directory only at the first byte of an entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && scan_result.valid && scan_result.status == STATUS_END_MARK
            |-> scan_status.byte_position == '0)
        else $error("end marker outside entry offset zero");

    // non-found results carry zero cluster and size
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_FOUND |-> m_tdata == '0)
        else $error("payload not zero on a non-found result");
`endif

endmodule

`default_nettype wire
